### rtl/core/mbss_pkg.sv
// Shared constants, register indexes and types for the masked byte signature scan.
// Used by mbss_window_cmp and masked_byte_signature_scan_core; no dependencies.
`default_nettype none

package mbss_pkg;

    localparam int PATTERN_MAX = 16;
    localparam int OFFSET_BITS = 32;

    localparam int ADDR_W     = 64;
    localparam int HITS_W     = 32;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int CARE_W     = 16;
    localparam int CFG_LEN_W  = 5;

    // Pattern length and fresh byte count hold 0..PATTERN_MAX
    localparam int LEN_W = $clog2(PATTERN_MAX + 1);
    // Index into the byte history
    localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_LOW    = 3'd0,
        REG_PATTERN_HIGH   = 3'd1,
        REG_CARE_MASK      = 3'd2,
        REG_PATTERN_LENGTH = 3'd3,
        REG_FIRST_ONLY     = 3'd4,
        REG_SEGMENT_BASE   = 3'd5
    } reg_idx_e;

    typedef logic [PATTERN_MAX-1:0][7:0] byte_vec_t;

    // Compare setup handed to the window comparator
    typedef struct packed {
        byte_vec_t              pattern;
        logic [PATTERN_MAX-1:0] care;
        logic [LEN_W-1:0]       len;
    } cmp_cfg_t;

endpackage

`default_nettype wire

### rtl/core/mbss_window_cmp.sv
// Masked compare of the byte history against the configured pattern.
// Depends on mbss_pkg; purely combinational.
`default_nettype none

module mbss_window_cmp
    import mbss_pkg::*;
(
    input  byte_vec_t hist,     // hist[0] is the current byte, hist[k] is k bytes back
    input  cmp_cfg_t  cfg,
    output logic      match
);

    always_comb begin
        logic             ok;
        logic [LEN_W-1:0] back;
        ok = 1'b1;
        for (int i = 0; i < PATTERN_MAX; i++) begin
            // pattern byte i sits len-1-i bytes back from the current byte
            back = cfg.len - LEN_W'(1) - LEN_W'(i);
            if ((LEN_W'(i) < cfg.len) && cfg.care[i] &&
                (hist[back[IDX_W-1:0]] != cfg.pattern[i])) begin
                ok = 1'b0;
            end
        end
        match = ok && (cfg.len != '0);
    end

endmodule

`default_nettype wire

### rtl/core/masked_byte_signature_scan_core.sv
// Masked byte signature scan: top level with handshake stages, scan state and config.
// Depends on mbss_pkg and mbss_window_cmp.
//
// Bytes of a memory segment enter on the s_ channel, one request per byte, in address
// order; s_segment_end marks the last byte. A request is compared, together with the
// bytes before it, against the configured pattern under the care mask. A result goes
// out on the m_ channel when a match ends at the byte or the byte is the last of the
// segment; other bytes give no result. Matches do not overlap, and with first_only set
// only the first match of a scan is reported. The last byte clears the scan state.
// A byte is registered at the input, then compared, and its result is registered at the
// output, which drives m_valid.
// Throughput: one byte per cycle while no result is held back by a low m_ready.
// When m_ready is low, the result waits in the output register and one more byte waits
// in the input register; s_ready then drops until the result is taken.
// Reset (aresetn low, synchronous) empties both stages, clears the scan state and
// returns the registers to zero, with pattern_length at 1.
// Configuration writes through cfg_we/cfg_index/cfg_wdata take effect at once;
// write them only while no request is in flight. Unknown indexes are ignored.
`default_nettype none

module masked_byte_signature_scan_core
    import mbss_pkg::*;
(
    input  wire                    aclk,
    input  wire                    aresetn,

    input  wire                    cfg_we,
    input  wire [CFG_IDX_W-1:0]    cfg_index,
    input  wire [CFG_DATA_W-1:0]   cfg_wdata,

    input  wire                    s_valid,
    output logic                   s_ready,
    input  wire [7:0]              s_data_byte,
    input  wire                    s_segment_end,

    output logic                   m_valid,
    input  wire                    m_ready,
    output logic                   m_is_match,
    output logic [ADDR_W-1:0]      m_match_address,
    output logic [HITS_W-1:0]      m_hits_so_far,
    output logic                   m_scan_done
);

    localparam int PAT_BITS = 8 * PATTERN_MAX;

    // Configuration registers
    logic [63:0]          pattern_low_reg;
    logic [63:0]          pattern_high_reg;
    logic [CARE_W-1:0]    care_mask_reg;
    logic [CFG_LEN_W-1:0] pattern_length_reg;
    logic                 first_only_reg;
    logic [ADDR_W-1:0]    segment_base_reg;

    // Input stage
    logic                 in_valid_reg;
    logic [7:0]           in_byte_reg;
    logic                 in_end_reg;

    // Scan state
    byte_vec_t            window_reg;
    byte_vec_t            window_next;
    logic [LEN_W-1:0]     fresh_reg;
    logic [LEN_W-1:0]     fresh_next;
    logic [OFFSET_BITS-1:0] offset_reg;
    logic [OFFSET_BITS-1:0] offset_next;
    logic [HITS_W-1:0]    hits_reg;
    logic [HITS_W-1:0]    hits_next;
    logic                 found_reg;
    logic                 found_next;

    // Output stage
    logic                 out_valid_reg;
    logic                 out_match_reg;
    logic [ADDR_W-1:0]    out_addr_reg;
    logic [HITS_W-1:0]    out_hits_reg;
    logic                 out_done_reg;

    logic                 proc;
    logic                 emit;
    logic                 hit;
    logic                 cmp_match;
    logic [LEN_W-1:0]     eff_len;
    logic [LEN_W-1:0]     fresh_inc;
    logic [OFFSET_BITS-1:0] start_off;
    logic [ADDR_W-1:0]    hit_addr;
    logic [127:0]         pattern_all;
    byte_vec_t            hist;
    cmp_cfg_t             cmp_cfg;

    // Handshake: process the held byte once the output register can take a result
    assign proc    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || proc;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_low_reg    <= '0;
            pattern_high_reg   <= '0;
            care_mask_reg      <= '0;
            pattern_length_reg <= CFG_LEN_W'(1);
            first_only_reg     <= 1'b0;
            segment_base_reg   <= '0;
        end else if (cfg_we) begin
            unique case (reg_idx_e'(cfg_index))
                REG_PATTERN_LOW:    pattern_low_reg    <= cfg_wdata;
                REG_PATTERN_HIGH:   pattern_high_reg   <= cfg_wdata;
                REG_CARE_MASK:      care_mask_reg      <= cfg_wdata[CARE_W-1:0];
                REG_PATTERN_LENGTH: pattern_length_reg <= cfg_wdata[CFG_LEN_W-1:0];
                REG_FIRST_ONLY:     first_only_reg     <= cfg_wdata[0];
                REG_SEGMENT_BASE:   segment_base_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg <= s_data_byte;
            in_end_reg  <= s_segment_end;
        end
    end

    // Compare setup; an overlong length acts as the full window
    assign pattern_all = {pattern_high_reg, pattern_low_reg};
    assign eff_len = (pattern_length_reg > CFG_LEN_W'(PATTERN_MAX)) ?
                     LEN_W'(PATTERN_MAX) : LEN_W'(pattern_length_reg);

    always_comb begin
        cmp_cfg.pattern = byte_vec_t'(pattern_all[PAT_BITS-1:0]);
        cmp_cfg.care    = care_mask_reg[PATTERN_MAX-1:0];
        cmp_cfg.len     = eff_len;
    end

    always_comb begin
        hist[0]        = in_byte_reg;
        window_next[0] = in_byte_reg;
        for (int k = 1; k < PATTERN_MAX; k++) begin
            hist[k]        = window_reg[k-1];
            window_next[k] = window_reg[k-1];
        end
    end

    mbss_window_cmp u_cmp (
        .hist  (hist),
        .cfg   (cmp_cfg),
        .match (cmp_match)
    );

    assign fresh_inc = (fresh_reg < LEN_W'(PATTERN_MAX)) ? fresh_reg + LEN_W'(1) : fresh_reg;
    assign hit = cmp_match && (fresh_inc >= eff_len) && !(first_only_reg && found_reg);

    assign start_off = offset_reg - OFFSET_BITS'(eff_len) + OFFSET_BITS'(1);
    assign hit_addr  = segment_base_reg + ADDR_W'(start_off);

    assign fresh_next  = hit ? '0 : fresh_inc;
    assign offset_next = offset_reg + OFFSET_BITS'(1);
    assign hits_next   = (hit && (hits_reg != '1)) ? hits_reg + HITS_W'(1) : hits_reg;
    assign found_next  = found_reg || hit;
    assign emit        = hit || in_end_reg;

    // Scan state: advance per processed byte, clear after the segment's last byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= '0;
            fresh_reg  <= '0;
            offset_reg <= '0;
            hits_reg   <= '0;
            found_reg  <= 1'b0;
        end else if (proc) begin
            if (in_end_reg) begin
                window_reg <= '0;
                fresh_reg  <= '0;
                offset_reg <= '0;
                hits_reg   <= '0;
                found_reg  <= 1'b0;
            end else begin
                window_reg <= window_next;
                fresh_reg  <= fresh_next;
                offset_reg <= offset_next;
                hits_reg   <= hits_next;
                found_reg  <= found_next;
            end
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (proc && emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc && emit) begin
            out_match_reg <= hit;
            out_addr_reg  <= hit ? hit_addr : '0;
            out_hits_reg  <= hits_next;
            out_done_reg  <= in_end_reg;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_is_match      = out_match_reg;
    assign m_match_address = out_addr_reg;
    assign m_hits_so_far   = out_hits_reg;
    assign m_scan_done     = out_done_reg;

    // Every result is a match or the end of a segment
    a_result_has_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_is_match || m_scan_done))
        else $error("result with neither match nor segment end");

    // A reported match is counted
    a_match_counted: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_is_match) |-> (m_hits_so_far != '0))
        else $error("match reported with zero hit count");

    // No match means no address
    a_addr_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_is_match) |-> (m_match_address == '0))
        else $error("address set on a result without match");

    // The last byte of a segment leaves a clean scan state
    a_scan_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (proc && in_end_reg) |=>
            (offset_reg == '0 && hits_reg == '0 && fresh_reg == '0 && !found_reg))
        else $error("scan state not cleared after segment end");

endmodule

`default_nettype wire
